### hw/rtl/ptnm_pkg.sv
// ----------------------------------------------------------------------------
// ptnm_pkg
// Shared types and codes of the page-to-node map: item structs, function
// codes, entry status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package ptnm_pkg;

    localparam int DEF_PAGES = 4096;
    localparam int DEF_NODES = 16;

    localparam int FUNC_W   = 2;
    localparam int PAGE_W   = 12;
    localparam int COUNT_W  = 13;
    localparam int NODE_W   = 5;
    localparam int STATUS_W = 2;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // Entry status codes; the spare code reads as unmapped
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MAPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
        logic [NODE_W-1:0]  node;
    } req_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]  found_node;
        logic               present;
        logic [COUNT_W-1:0] ignored;
        logic               clipped;
    } rsp_item_t;

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_LOOK,
        SEQ_RUN
    } seq_state_t;

endpackage

### hw/rtl/page_to_node_map_core.sv
// Sequencing: a lookup reads its entry as the item is taken, then registers
// its result; an add or remove walks its run page by page; empty, invalid-node
// and out-of-range items register their result straight from the idle state.
// Throughput: one item in flight, so a new transfer waits for the result to
// leave; along a run, one page a cycle. Reset: a clearing pass writes every
// entry as unmapped, with no input taken until it ends.
// ----------------------------------------------------------------------------
// page_to_node_map_core
// Flat per-page home-node table held in one synchronous memory. Each entry
// stores a home node and a status (unmapped, mapped, removed). Lookups read
// one entry; adds and removes walk a run of pages, reading the next entry
// while writing back the current one.
// ----------------------------------------------------------------------------
module page_to_node_map_core #(
    parameter int PAGES = ptnm_pkg::DEF_PAGES,
    parameter int NODES = ptnm_pkg::DEF_NODES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ptnm_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ptnm_pkg::rsp_item_t rsp
);
    import ptnm_pkg::*;

    localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int HW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EW = HW + STATUS_W;
    // wide enough for the page field and the table size
    localparam int XW = 18;

    localparam logic [AW-1:0]     LAST_ADDR = AW'(PAGES - 1);
    localparam logic [XW-1:0]     PAGES_X   = XW'(PAGES);
    localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(NODES);

    // Entry memory: {home, status}
    logic [EW-1:0] mem [PAGES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer and item registers
    seq_state_t         state_reg,  state_next;
    logic [AW-1:0]      clr_reg,    clr_next;
    logic [AW-1:0]      addr_reg,   addr_next;
    logic [COUNT_W-1:0] left_reg,   left_next;
    logic [COUNT_W-1:0] ign_reg,    ign_next;
    logic [FUNC_W-1:0]  func_reg,   func_next;
    logic [HW-1:0]      node_reg,   node_next;
    logic               clip_reg,   clip_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg,    rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        left_reg <= left_next;
        ign_reg  <= ign_next;
        func_reg <= func_next;
        node_reg <= node_next;
        clip_reg <= clip_next;
        rsp_reg  <= rsp_next;
    end

    // Cut the incoming run at the table end
    logic [XW-1:0]      page_x;
    logic [XW-1:0]      count_x;
    logic [XW-1:0]      room_x;
    logic               page_oob;
    logic [COUNT_W-1:0] run_len;
    logic               run_clip;
    logic [AW-1:0]      page_addr;
    logic               node_bad;

    always_comb
    begin
        page_x    = XW'(req.page);
        count_x   = XW'(req.count);
        page_oob  = (page_x >= PAGES_X);
        room_x    = PAGES_X - page_x;
        page_addr = page_x[AW-1:0];
        node_bad  = (32'(req.node) >= NODES);
        run_len   = req.count;
        run_clip  = 1'b0;
        if (req.count == '0)
        begin
            run_len = '0;
        end
        else if (page_oob)
        begin
            run_len  = '0;
            run_clip = 1'b1;
        end
        else if (count_x > room_x)
        begin
            run_len  = COUNT_W'(room_x);
            run_clip = 1'b1;
        end
    end

    // Decode the entry read back for the current page
    logic [HW-1:0]       rd_home;
    logic [STATUS_W-1:0] rd_status;
    logic                rd_mapped;
    logic                rd_known;

    assign rd_home   = rd_data_reg[EW-1:STATUS_W];
    assign rd_status = rd_data_reg[STATUS_W-1:0];
    assign rd_mapped = (rd_status == ST_MAPPED);
    assign rd_known  = rd_mapped || (rd_status == ST_REMOVED);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        ign_next       = ign_reg;
        func_next      = func_reg;
        node_next      = node_reg;
        clip_next      = clip_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = rd_data_reg;
        mem_raddr      = page_addr;
        req_stall      = 1'b1;

        unique case (state_reg)
            SEQ_CLEAR:
            begin
                // write every entry as unmapped, home zero
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            SEQ_IDLE:
            begin
                // take an item only when the result slot is free at the edge
                req_stall = rsp_valid_reg && rsp_stall;
                if (req_valid && !req_stall)
                begin
                    func_next = req.func;
                    node_next = HW'(req.node);
                    clip_next = run_clip;
                    addr_next = page_addr;
                    left_next = run_len;
                    ign_next  = '0;
                    rsp_next.found_node = NODE_NONE;
                    rsp_next.present    = 1'b0;
                    rsp_next.ignored    = '0;
                    rsp_next.clipped    = 1'b0;
                    unique case (req.func)
                        FUNC_LOOKUP:
                        begin
                            if (page_oob)
                            begin
                                rsp_next.clipped = 1'b1;
                                rsp_valid_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = SEQ_LOOK;
                            end
                        end
                        FUNC_ADD:
                        begin
                            if (run_len == '0 || node_bad)
                            begin
                                // empty run or invalid node; an invalid node reports the whole run as ignored
                                rsp_next.ignored = node_bad ? run_len : '0;
                                rsp_next.clipped = run_clip;
                                rsp_valid_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = SEQ_RUN;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (run_len == '0)
                            begin
                                rsp_next.clipped = run_clip;
                                rsp_valid_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = SEQ_RUN;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            SEQ_LOOK:
            begin
                rsp_next.found_node = rd_known ? NODE_W'(rd_home) : NODE_NONE;
                rsp_next.present    = rd_mapped;
                rsp_next.ignored    = '0;
                rsp_next.clipped    = 1'b0;
                rsp_valid_next      = 1'b1;
                state_next          = SEQ_IDLE;
            end

            SEQ_RUN:
            begin
                // write back the current page while reading the next one, if any
                mem_we = 1'b1;
                if (func_reg == FUNC_ADD)
                begin
                    if (!rd_mapped)
                    begin
                        mem_wdata = {node_reg, ST_MAPPED};
                    end
                    else if (rd_home != node_reg)
                    begin
                        ign_next = ign_reg + 1'b1;
                    end
                end
                else if (rd_mapped)
                begin
                    mem_wdata = {rd_home, ST_REMOVED};
                end

                if (left_reg == COUNT_W'(1))
                begin
                    rsp_next.found_node = NODE_NONE;
                    rsp_next.present    = 1'b0;
                    rsp_next.ignored    = ign_next;
                    rsp_next.clipped    = clip_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = SEQ_IDLE;
                end
                else
                begin
                    mem_raddr = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
